// ===== rtl/lru_pkg.sv =====
// Package: shared types and constants of the LRU page replacement core.
`default_nettype none

package lru_pkg;

  // Default sizes handed to the top level
  localparam int MaxFramesDef = 16;
  localparam int PageBitsDef  = 16;

  // Fixed field widths
  localparam int CFG_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int STAMP_W = 32;
  localparam int TOTAL_W = 32;

  // Reset value of the frame count register
  localparam logic [CFG_W-1:0] CfgReset = 5'd16;

  // All ones: saturation point of stamps and totals
  localparam logic [STAMP_W-1:0] StampMax = '1;
  localparam logic [TOTAL_W-1:0] TotalMax = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } lru_state_e;

endpackage : lru_pkg

`default_nettype wire

// ===== rtl/lru_page_replacement_core.sv =====
// Top level: LRU page replacement core with a frame memory and a scan sequencer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  in      | input     | in_valid_i/in_stall_o | page_i, end_of_string_i
//  out     | output    | out_valid_o/out_stall_i | hit_o, slot_o, evicted_valid_o,
//          |           |                       | evicted_page_o, hit_total_o,
//          |           |                       | fault_total_o, order_lost_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (frames_in_use)
//
// After a request is accepted, the scan reads the N frames in use, N being the frame count in
// use, one frame a cycle through the single port of the frame memory; then the chosen frame
// is written back.
// Reset clears valid bits, use clock, totals and the sequencer; the memory is not cleared.
// A result waiting on out_stall_i does not block the next request; the write-back of that
// next request waits until the output register is free.
`default_nettype none

module lru_page_replacement_core
  import lru_pkg::*;
#(
  parameter int MAX_FRAMES = MaxFramesDef,
  parameter int PAGE_BITS  = PageBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Reference requests
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [PAGE_BITS-1:0] page_i,
  input  wire logic                 end_of_string_i,
  // Results
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      hit_o,
  output logic [SLOT_W-1:0]         slot_o,
  output logic                      evicted_valid_o,
  output logic [PAGE_BITS-1:0]      evicted_page_o,
  output logic [TOTAL_W-1:0]        hit_total_o,
  output logic [TOTAL_W-1:0]        fault_total_o,
  output logic                      order_lost_o,
  // Configuration
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int ENTRY_W = PAGE_BITS + STAMP_W;

  // Frame memory: {page, stamp}
  logic [ENTRY_W-1:0] mem_q [MAX_FRAMES];
  logic [ENTRY_W-1:0] rd_data_q;

  // Control state
  lru_state_e           state_q, state_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [MAX_FRAMES-1:0] valid_q;
  logic [STAMP_W-1:0]   clock_q;
  logic [TOTAL_W-1:0]   hits_q, faults_q;
  logic [CNT_W-1:0]     rd_idx_q;
  logic                 chk_v_q;
  logic                 out_valid_q;

  // Request and scan payload
  logic [PAGE_BITS-1:0] tag_q;
  logic                 last_q;
  logic [CNT_W-1:0]     count_q;
  logic [IDX_W-1:0]     chk_idx_q;
  logic                 found_q, empty_q, have_min_q;
  logic [IDX_W-1:0]     match_idx_q, empty_idx_q, min_idx_q;
  logic [STAMP_W-1:0]   min_stamp_q;
  logic [PAGE_BITS-1:0] min_page_q;

  // Result register
  logic                 hit_q, evict_q, lost_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [PAGE_BITS-1:0] evict_page_q;
  logic [TOTAL_W-1:0]   hit_tot_q, fault_tot_q;

  // Combinational control
  logic                 in_acc, rd_en, scan_done, wb_go;
  logic [CNT_W-1:0]     count_clamped;
  logic [IDX_W-1:0]     pos;
  logic [STAMP_W-1:0]   clock_next;
  logic [TOTAL_W-1:0]   hits_next, faults_next;
  logic [PAGE_BITS-1:0] rd_page;
  logic [STAMP_W-1:0]   rd_stamp;
  logic                 rd_frame_valid;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Clamp the configured frame count to 1 .. MAX_FRAMES
  always_comb begin
    priority if (cfg_q == '0) begin
      count_clamped = CNT_W'(1);
    end else if (int'(cfg_q) > MAX_FRAMES) begin
      count_clamped = CNT_W'(MAX_FRAMES);
    end else begin
      count_clamped = CNT_W'(cfg_q);
    end
  end

  // Split the read word
  assign rd_page        = rd_data_q[ENTRY_W-1:STAMP_W];
  assign rd_stamp       = rd_data_q[STAMP_W-1:0];
  assign rd_frame_valid = valid_q[chk_idx_q];

  // Pick the frame to update and the new counts
  always_comb begin
    priority if (found_q) begin
      pos = match_idx_q;
    end else if (empty_q) begin
      pos = empty_idx_q;
    end else begin
      pos = min_idx_q;
    end
    clock_next  = (clock_q == StampMax) ? clock_q : clock_q + 1'b1;
    hits_next   = (found_q && hits_q != TotalMax) ? hits_q + 1'b1 : hits_q;
    faults_next = (!found_q && faults_q != TotalMax) ? faults_q + 1'b1 : faults_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:  if (scan_done) state_d = ST_WRITE;
      ST_WRITE: if (wb_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    scan_done  = 1'b0;
    wb_go      = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_SCAN: begin
        rd_en     = (rd_idx_q < count_q);
        scan_done = (rd_idx_q == count_q) && !chk_v_q;
      end
      ST_WRITE: wb_go = !out_valid_q || !out_stall_i;
      default:  in_stall_o = 1'b1;
    endcase
  end

  // Frame memory: one read or one write a cycle
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx_q[IDX_W-1:0]];
    end
    if (wb_go) begin
      mem_q[pos] <= {tag_q, clock_next};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CfgReset;
      valid_q     <= '0;
      clock_q     <= '0;
      hits_q      <= '0;
      faults_q    <= '0;
      rd_idx_q    <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      // Advance the read pointer and the check stage
      if (in_acc) begin
        rd_idx_q <= '0;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      chk_v_q <= rd_en;
      // Raise the result on write-back, drop it once taken
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Write back the frame and counts, or clear them at end of string
      if (wb_go) begin
        if (last_q) begin
          valid_q  <= '0;
          clock_q  <= '0;
          hits_q   <= '0;
          faults_q <= '0;
        end else begin
          valid_q[pos] <= 1'b1;
          clock_q      <= clock_next;
          hits_q       <= hits_next;
          faults_q     <= faults_next;
        end
      end
    end
  end

  // Request capture and scan accumulators
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tag_q      <= page_i;
      last_q     <= end_of_string_i;
      count_q    <= count_clamped;
      found_q    <= 1'b0;
      empty_q    <= 1'b0;
      have_min_q <= 1'b0;
    end
    if (rd_en) begin
      chk_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    if (chk_v_q) begin
      // Hold the first matching valid frame
      if (rd_frame_valid && rd_page == tag_q && !found_q) begin
        found_q     <= 1'b1;
        match_idx_q <= chk_idx_q;
      end
      // Hold the first empty frame
      if (!rd_frame_valid && !empty_q) begin
        empty_q     <= 1'b1;
        empty_idx_q <= chk_idx_q;
      end
      // Track the oldest stamp, lowest index on ties
      if (rd_frame_valid && (!have_min_q || rd_stamp < min_stamp_q)) begin
        have_min_q  <= 1'b1;
        min_stamp_q <= rd_stamp;
        min_idx_q   <= chk_idx_q;
        min_page_q  <= rd_page;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      hit_q        <= found_q;
      slot_q       <= SLOT_W'(pos);
      evict_q      <= !found_q && !empty_q;
      evict_page_q <= (!found_q && !empty_q) ? min_page_q : '0;
      hit_tot_q    <= hits_next;
      fault_tot_q  <= faults_next;
      lost_q       <= (clock_next == StampMax);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_valid_o = evict_q;
  assign evicted_page_o  = evict_page_q;
  assign hit_total_o     = hit_tot_q;
  assign fault_total_o   = fault_tot_q;
  assign order_lost_o    = lost_q;

  // A request starts a scan, so the input stalls right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // A hit result carries a nonzero hit total, a fault a nonzero fault total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o ? (hit_total_o != '0) : (fault_total_o != '0)))
    else $error("result total does not count this request");

  // Eviction only on a fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_valid_o) |-> !hit_o)
    else $error("eviction reported on a hit");

  // The scan pointer never passes the frame count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_idx_q <= count_q))
    else $error("scan pointer beyond frame count");

  // Write-back happens only when the output register can take the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !wb_go)
    else $error("write-back overran a waiting result");

endmodule : lru_page_replacement_core

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the LRU page replacement core: references checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lru_pkg::*;

  localparam int RandomRefs  = 1290;
  localparam int QuietLimit  = 4000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 40;
  localparam int ReportLimit = 10;

  localparam logic [PageBitsDef-1:0] PageZero = '0;
  localparam logic [PageBitsDef-1:0] PageOnes = '1;

  // One result of the core, field for field
  typedef struct packed {
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
    logic                   evicted_valid;
    logic [PageBitsDef-1:0] evicted_page;
    logic [TOTAL_W-1:0]     hit_total;
    logic [TOTAL_W-1:0]     fault_total;
    logic                   order_lost;
  } lru_outcome_t;

  // Frame table mirror and the queue of outcomes still owed by the core
  class lru_page_tracker;
    logic [PageBitsDef-1:0] tag_of   [MaxFramesDef];
    bit                     held     [MaxFramesDef];
    logic [STAMP_W-1:0]     stamp_of [MaxFramesDef];
    logic [STAMP_W-1:0]     use_clock;
    logic [TOTAL_W-1:0]     hits_seen;
    logic [TOTAL_W-1:0]     faults_seen;
    logic [CFG_W-1:0]       frames_cfg;
    lru_outcome_t           awaited_results[$];
    int                     errors;

    function new();
      frames_cfg = CfgReset;
      errors     = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (held[j]) held[j] = 1'b0;
      use_clock   = '0;
      hits_seen   = '0;
      faults_seen = '0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] value);
      frames_cfg = value;
    endfunction

    // Look up one reference, update the table and return the outcome
    function lru_outcome_t resolve_reference(logic [PageBitsDef-1:0] pg, logic eos);
      lru_outcome_t res;
      int           count;
      int           pos;
      bit           found;
      bit           empty;
      res   = '0;
      pos   = 0;
      found = 1'b0;
      empty = 1'b0;
      count = int'(frames_cfg);
      if (count < 1) count = 1;
      if (count > MaxFramesDef) count = MaxFramesDef;
      // lowest matching valid frame wins
      for (int j = 0; j < count; j++) begin
        if (!found && held[j] && tag_of[j] == pg) begin
          pos   = j;
          found = 1'b1;
        end
      end
      if (!found) begin
        for (int j = 0; j < count; j++) begin
          if (!empty && !held[j]) begin
            pos   = j;
            empty = 1'b1;
          end
        end
        // no empty frame: replace the lowest frame with the oldest stamp
        if (!empty) begin
          pos = 0;
          for (int j = 1; j < count; j++) begin
            if (stamp_of[j] < stamp_of[pos]) pos = j;
          end
          res.evicted_valid = 1'b1;
          res.evicted_page  = tag_of[pos];
        end
        tag_of[pos] = pg;
        held[pos]   = 1'b1;
        if (faults_seen != TotalMax) faults_seen++;
      end else begin
        if (hits_seen != TotalMax) hits_seen++;
      end
      if (use_clock != StampMax) use_clock++;
      stamp_of[pos]   = use_clock;
      res.hit         = found;
      res.slot        = SLOT_W'(pos);
      res.hit_total   = hits_seen;
      res.fault_total = faults_seen;
      res.order_lost  = (use_clock == StampMax);
      if (eos) clear_string();
      return res;
    endfunction

    function void note_reference(logic [PageBitsDef-1:0] pg, logic eos);
      awaited_results.push_back(resolve_reference(pg, eos));
    endfunction

    function void check_result(lru_outcome_t got);
      lru_outcome_t want;
      bit           bad;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: result with nothing outstanding: hit %0b slot %0d", $realtime,
                   got.hit, got.slot);
        return;
      end
      want = awaited_results.pop_front();
      bad  = (got.hit !== want.hit) || (got.slot !== want.slot) ||
             (got.evicted_valid !== want.evicted_valid) ||
             (got.evicted_page !== want.evicted_page) ||
             (got.hit_total !== want.hit_total) ||
             (got.fault_total !== want.fault_total) ||
             (got.order_lost !== want.order_lost);
      if (bad) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("%0t: mismatch, expected / actual:", $realtime);
          $display("  hit %0b/%0b slot %0d/%0d evicted %0b/%0b page %h/%h", want.hit, got.hit,
                   want.slot, got.slot, want.evicted_valid, got.evicted_valid,
                   want.evicted_page, got.evicted_page);
          $display("  hits %0d/%0d faults %0d/%0d order_lost %0b/%0b", want.hit_total,
                   got.hit_total, want.fault_total, got.fault_total, want.order_lost,
                   got.order_lost);
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [PageBitsDef-1:0] page_i;
  logic                   end_of_string_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   hit_o;
  logic [SLOT_W-1:0]      slot_o;
  logic                   evicted_valid_o;
  logic [PageBitsDef-1:0] evicted_page_o;
  logic [TOTAL_W-1:0]     hit_total_o;
  logic [TOTAL_W-1:0]     fault_total_o;
  logic                   order_lost_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i;

  lru_page_tracker tracker;
  int              burst_left  = 0;
  int              quiet_cycles = 0;
  bit              hold_due    = 1'b0;

  lru_page_replacement_core #(
    .MAX_FRAMES(MaxFramesDef),
    .PAGE_BITS (PageBitsDef)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .page_i         (page_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .hit_total_o    (hit_total_o),
    .fault_total_o  (fault_total_o),
    .order_lost_o   (order_lost_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Sample both channels: check the result first, then note the new request
  always @(posedge clk_i) begin
    lru_outcome_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.hit           = hit_o;
        seen.slot          = slot_o;
        seen.evicted_valid = evicted_valid_o;
        seen.evicted_page  = evicted_page_o;
        seen.hit_total     = hit_total_o;
        seen.fault_total   = fault_total_o;
        seen.order_lost    = order_lost_o;
        tracker.check_result(seen);
      end
      if (in_valid_i && !in_stall_o) tracker.note_reference(page_i, end_of_string_i);
    end
  end

  // Abort when no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side backpressure: free, random, mostly stalled, fully stalled, and one long hold
  initial begin
    int mode;
    int span;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        repeat (HoldCycles) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      mode = $urandom_range(0, 9);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0, 1, 2, 3: out_stall_i <= 1'b0;
          4, 5, 6, 7: out_stall_i <= ($urandom_range(0, 2) == 0);
          8:          out_stall_i <= ($urandom_range(0, 3) != 0);
          default:    out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  // Offer one reference, in bursts with idle gaps between them
  task automatic send_reference(input logic [PageBitsDef-1:0] pg, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    page_i          <= pg;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tracker.awaited_results.size() != 0) @(negedge clk_i);
  endtask

  // Write the frame count while the core is idle
  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain_requests();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_frames(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0]       plan [8];
    logic [PageBitsDef-1:0] pool [24];
    logic [CFG_W-1:0]       frames;
    logic [PageBitsDef-1:0] pg;
    int                     sent;
    int                     phase;
    int                     active;
    int                     pool_n;
    int                     len;
    int                     pick;
    tracker         = new();
    plan            = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd15};
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    page_i          = '0;
    end_of_string_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Four frames: fill, hit, then replace the least recently used page
    write_frames(5'd4);
    send_reference(PageZero, 1'b0);
    send_reference(PageOnes, 1'b0);
    send_reference(PageZero, 1'b0);
    send_reference(16'hAAAA, 1'b0);
    send_reference(16'h5555, 1'b0);
    send_reference(PageOnes, 1'b0);
    send_reference(16'h1234, 1'b0);
    // Shrink to one frame mid-string, leaving a stale copy of a tag above it
    write_frames(5'd1);
    send_reference(16'h00F0, 1'b0);
    send_reference(PageOnes, 1'b0);
    // Zero frames acts as one
    write_frames(5'd0);
    send_reference(PageOnes, 1'b0);
    // Oversized count acts as the maximum; duplicate tags hit the lowest frame
    write_frames(5'd31);
    send_reference(PageOnes, 1'b0);
    send_reference(16'h5555, 1'b0);
    send_reference(16'h0F0F, 1'b1);
    send_reference(16'h0F0F, 1'b0);
    send_reference(16'h8001, 1'b1);

    // Random phases, each with its own frame count and page working set
    sent     = 0;
    phase    = 0;
    while (sent < RandomRefs) begin
      if (phase < 8) frames = plan[phase];
      else if ($urandom_range(0, 4) == 0) frames = CFG_W'($urandom_range(0, 31));
      else frames = CFG_W'($urandom_range(1, MaxFramesDef));
      phase++;
      write_frames(frames);
      // Start the long result hold while references keep coming
      if (phase == 1) hold_due = 1'b1;
      active = (frames == 0) ? 1 : (frames > MaxFramesDef) ? MaxFramesDef : int'(frames);
      pool_n = active + $urandom_range(1, 6);
      foreach (pool[k]) pool[k] = PageBitsDef'($urandom_range(0, 65535));
      len = $urandom_range(30, 140);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) pg = pool[$urandom_range(0, pool_n - 1)];
        else if (pick < 92) pg = PageBitsDef'($urandom_range(0, 65535));
        else if (pick < 96) pg = PageZero;
        else pg = PageOnes;
        send_reference(pg, $urandom_range(0, 39) == 0);
        sent++;
      end
    end

    drain_requests();
    repeat (DrainCycles) @(negedge clk_i);
    if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lru_pkg.sv
rtl/lru_page_replacement_core.sv
tb/sv/tb.sv
